// ===== rtl/core/cifr_pkg.sv =====
// Shared types and constants of the camera image fragment reassembler.
package cifr_pkg;

  localparam int IMAGE_BYTES_DEF = 65535;
  localparam int MAX_PACKETS_DEF = 64;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_OUTCOME = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [1:0] TYPE_DIGIT_SHORT = 2'd2;
  localparam logic [1:0] TYPE_DIGIT_LONG  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic        last_of_packet;
    logic [15:0] read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  request_id;
    logic [1:0]  request_type_digit;
    logic        success;
    logic [15:0] image_size;
    logic [7:0]  read_byte;
  } rsp_t;

  // Parser status seen by the top level.
  typedef struct packed {
    logic [3:0]  request_id;
    logic        success;
    logic [15:0] image_size;
    logic        good_bank;
  } stat_t;

endpackage

// ===== rtl/core/cifr_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cifr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cifr_parser.sv =====
// Datagram header parser, message state and payload write generation.
module cifr_parser #(
  parameter int IMAGE_BYTES = cifr_pkg::IMAGE_BYTES_DEF,
  parameter int MAX_PACKETS = cifr_pkg::MAX_PACKETS_DEF,
  localparam int AW = $clog2(IMAGE_BYTES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  cifr_pkg::req_t  req,
  input  logic            header_mode,
  output logic            wr_en,
  output logic [AW:0]     wr_addr,
  output logic [7:0]      wr_data,
  output cifr_pkg::stat_t stat
);
  import cifr_pkg::*;

  localparam int PCW = $clog2(MAX_PACKETS + 1);

  typedef enum logic [2:0] {
    PK_HDR = 3'b001,
    PK_PAY = 3'b010,
    PK_IGN = 3'b100
  } pk_t;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_DONE = 3'b100
  } ph_t;

  typedef struct packed {
    pk_t         pk;
    logic        failed;
    logic [26:0] exp_size;
    logic [16:0] rx;
    logic [5:0]  pstart;
    logic [15:0] pbase;
  } st_t;

  localparam logic [15:0] POS_ID_END   = 16'd1;
  localparam logic [15:0] POS_OFF_END  = 16'd7;
  localparam logic [15:0] POS_SIZE_END = 16'd15;
  localparam logic [15:0] HDR_LEN      = 16'd8;
  localparam logic [5:0]  PSTART_SHORT = 6'd25;
  localparam logic [5:0]  PSTART_LONG  = 6'd37;
  localparam logic [26:0] SIZE_DEFAULT = 27'd100;
  localparam logic [3:0]  ID_LAST      = 4'd9;

  logic [3:0]     rc, rc_next;
  logic           good_bank, good_bank_next;
  logic [15:0]    pos, pos_next;
  st_t            st, st_next;
  logic [PCW-1:0] pcnt, pcnt_next;
  ph_t            ph, ph_next;
  logic [26:0]    acc, acc_next;
  logic           neg, neg_next;

  // Apply the end-of-field check for header position p.
  function automatic st_t hdr_check(input logic [15:0] p, input logic [26:0] a,
                                    input logic n, input logic [15:0] plen,
                                    input st_t s, input logic mode,
                                    input logic [3:0] eid);
    st_t         r;
    logic        bad;
    logic [17:0] sum;
    logic [5:0]  ps;
    r   = s;
    bad = (n && a != '0) || a > 27'(IMAGE_BYTES);
    sum = {1'b0, s.rx} + {2'b0, plen - HDR_LEN};
    ps  = mode ? PSTART_SHORT : PSTART_LONG;
    if (s.pk == PK_HDR) begin
      if (p == POS_ID_END) begin
        if ((n && a != '0) || a != {23'b0, eid}) r.pk = PK_IGN;
      end else if (p == POS_OFF_END) begin
        if (bad) begin
          r.failed = 1'b1;
          r.pk = PK_IGN;
        end else if (a != '0) begin
          if (plen > HDR_LEN && {11'b0, plen} < s.exp_size) begin
            r.pk     = PK_PAY;
            r.pstart = HDR_LEN[5:0];
            r.pbase  = a[15:0];
            r.rx     = sum[17] ? '1 : sum[16:0];
          end else begin
            r.failed = 1'b1;
            r.pk = PK_IGN;
          end
        end else if (plen <= HDR_LEN) begin
          r.failed = 1'b1;
          r.pk = PK_IGN;
        end
      end else if (p == POS_SIZE_END) begin
        if (bad) begin
          r.failed = 1'b1;
          r.pk = PK_IGN;
        end else begin
          r.exp_size = a;
          r.pstart   = ps;
          if (plen < {10'b0, ps}) begin
            r.rx = '0;
            r.failed = 1'b1;
            r.pk = PK_IGN;
          end else begin
            r.pk    = PK_PAY;
            r.pbase = '0;
            r.rx    = {1'b0, plen - {10'b0, ps}};
          end
        end
      end
    end
    return r;
  endfunction

  logic        work;
  logic [3:0]  exp_id;
  logic [7:0]  b;
  logic        digit;
  ph_t         ph0, ph1;
  logic [26:0] acc0, acc1;
  logic        neg0, neg1;
  logic [16:0] idx;
  logic [15:0] rel;

  assign work   = ~good_bank;
  assign exp_id = (rc == 4'd0) ? ID_LAST : rc - 4'd1;
  assign b      = (pos < req.packet_length) ? req.data_byte : 8'd0;
  assign digit  = b >= "0" && b <= "9";
  assign rel    = pos - {10'b0, st.pstart};
  assign idx    = {1'b0, st.pbase} + {1'b0, rel};

  always_comb begin
    rc_next        = rc;
    good_bank_next = good_bank;
    pos_next       = pos;
    st_next        = st;
    pcnt_next      = pcnt;
    ph_next        = ph;
    acc_next       = acc;
    neg_next       = neg;
    wr_en          = 1'b0;
    wr_addr        = {work, idx[AW-1:0]};
    wr_data        = b;

    // digit parser for the current byte
    if (pos == 16'd0 || pos == 16'd2 || pos == HDR_LEN) begin
      ph0 = PH_SKIP;
      acc0 = '0;
      neg0 = 1'b0;
    end else begin
      ph0 = ph;
      acc0 = acc;
      neg0 = neg;
    end
    ph1 = ph0;
    acc1 = acc0;
    neg1 = neg0;
    unique case (ph0)
      PH_SKIP: begin
        if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
          ph1 = PH_SKIP;
        end else if (b == "+" || b == "-") begin
          neg1 = (b == "-");
          ph1 = PH_NUM;
        end else if (digit) begin
          acc1 = {19'b0, b - "0"};
          ph1 = PH_NUM;
        end else begin
          ph1 = PH_DONE;
        end
      end
      PH_NUM: begin
        if (digit) acc1 = (acc0 << 3) + (acc0 << 1) + {19'b0, b - "0"};
        else ph1 = PH_DONE;
      end
      PH_DONE: ph1 = PH_DONE;
      default: ph1 = PH_DONE;
    endcase

    if (accept) begin
      unique case (req.opcode)
        OP_START: begin
          rc_next = (rc == ID_LAST) ? 4'd0 : rc + 4'd1;
          pos_next = '0;
          st_next.exp_size = SIZE_DEFAULT;
          st_next.rx = '0;
          st_next.failed = 1'b0;
          st_next.pk = PK_IGN;
          pcnt_next = '0;
        end
        OP_BYTE: begin
          if (!st.failed) begin
            if (pos == 16'd0) begin
              if (pcnt >= PCW'(MAX_PACKETS)) begin
                st_next.pk = PK_IGN;
              end else begin
                pcnt_next = pcnt + PCW'(1);
                st_next.pk = (req.packet_length == 16'd0) ? PK_IGN : PK_HDR;
              end
            end
            if (st_next.pk == PK_HDR && pos <= POS_SIZE_END) begin
              ph_next = ph1;
              acc_next = acc1;
              neg_next = neg1;
              st_next = hdr_check(pos, acc1, neg1, req.packet_length, st_next,
                                  header_mode, exp_id);
            end else if (st_next.pk == PK_PAY && pos >= {10'b0, st.pstart} &&
                         pos < req.packet_length) begin
              wr_en = idx < 17'(IMAGE_BYTES);
            end
            // a short datagram ends its header with zero bytes
            if (req.last_of_packet) begin
              if (pos < POS_ID_END)
                st_next = hdr_check(POS_ID_END, acc1, neg1, req.packet_length,
                                    st_next, header_mode, exp_id);
              if (pos < POS_OFF_END)
                st_next = hdr_check(POS_OFF_END, (pos >= 16'd2) ? acc1 : '0,
                                    (pos >= 16'd2) && neg1, req.packet_length,
                                    st_next, header_mode, exp_id);
              if (pos < POS_SIZE_END)
                st_next = hdr_check(POS_SIZE_END, (pos >= HDR_LEN) ? acc1 : '0,
                                    (pos >= HDR_LEN) && neg1, req.packet_length,
                                    st_next, header_mode, exp_id);
            end
          end
          pos_next = req.last_of_packet ? 16'd0 : ((pos == '1) ? pos : pos + 16'd1);
        end
        OP_FINISH: begin
          if (stat.success) begin
            good_bank_next = work;
          end
          st_next.failed = 1'b1;
          st_next.pk = PK_IGN;
          pos_next = '0;
        end
        OP_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.request_id = rc;
  assign stat.success    = !st.failed && {10'b0, st.rx} == st.exp_size;
  assign stat.image_size = st.rx[15:0];
  assign stat.good_bank  = good_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      rc        <= '0;
      good_bank <= 1'b0;
      pos       <= '0;
      st        <= '{pk: PK_IGN, failed: 1'b0, exp_size: SIZE_DEFAULT, rx: '0,
                     pstart: '0, pbase: '0};
      pcnt      <= '0;
      ph        <= PH_SKIP;
      acc       <= '0;
      neg       <= 1'b0;
    end else begin
      rc        <= rc_next;
      good_bank <= good_bank_next;
      pos       <= pos_next;
      st        <= st_next;
      pcnt      <= pcnt_next;
      ph        <= ph_next;
      acc       <= acc_next;
      neg       <= neg_next;
    end
  end

endmodule

// ===== rtl/core/camera_image_fragment_reassembler_top.sv =====
// Top level of the camera image fragment reassembler.
// Takes one item per cycle while req_stall is low: datagram bytes stream at
// full rate into the image RAM. A start request is answered without waiting
// for the sweep; the working bank is then swept to zero, one byte a cycle, over
// its 2**clog2(IMAGE_BYTES) bytes (65536 by default) while req_stall is high;
// after reset both banks are swept. A read's byte comes from a registered RAM
// read, and every result leaves through a two-entry output pipeline.
module camera_image_fragment_reassembler_top #(
  parameter int IMAGE_BYTES = cifr_pkg::IMAGE_BYTES_DEF,
  parameter int MAX_PACKETS = cifr_pkg::MAX_PACKETS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           req_valid,
  output logic           req_stall,
  input  cifr_pkg::req_t req_item,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cifr_pkg::rsp_t rsp_item
);
  import cifr_pkg::*;

  localparam int AW = $clog2(IMAGE_BYTES);

  logic        header_mode;
  logic        accept;
  logic        p_wr_en;
  logic [AW:0] p_wr_addr;
  logic [7:0]  p_wr_data;
  stat_t       stat;

  logic        clr_busy;
  logic [AW:0] clr_addr, clr_last;

  logic        ram_we, ram_re;
  logic [AW:0] ram_waddr;
  logic [7:0]  ram_wdata, ram_rdata;

  logic        p1_valid, p1_rd, p1_rd_next;
  rsp_t        p1_rsp, p1_rsp_next;
  logic        o_valid;
  rsp_t        o_rsp, o_rsp_next;
  logic        p1_adv;

  assign p1_adv    = !o_valid || !rsp_stall;
  assign req_stall = clr_busy || (p1_valid && !p1_adv);
  assign accept    = req_valid && !req_stall;

  cifr_parser #(
    .IMAGE_BYTES(IMAGE_BYTES),
    .MAX_PACKETS(MAX_PACKETS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req         (req_item),
    .header_mode (header_mode),
    .wr_en       (p_wr_en),
    .wr_addr     (p_wr_addr),
    .wr_data     (p_wr_data),
    .stat        (stat)
  );

  assign ram_we    = clr_busy || p_wr_en;
  assign ram_waddr = clr_busy ? clr_addr : p_wr_addr;
  assign ram_wdata = clr_busy ? 8'd0 : p_wr_data;
  assign ram_re    = accept && req_item.opcode == OP_READ;

  cifr_ram #(
    .WIDTH(8),
    .DEPTH(2 ** (AW + 1))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr ({stat.good_bank, req_item.read_index[AW-1:0]}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header_mode <= 1'b0;
    end else if (cfg_we) begin
      header_mode <= cfg_wdata;
    end
  end

  // bank clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      clr_last <= '1;
    end else if (accept && req_item.opcode == OP_START) begin
      clr_busy <= 1'b1;
      clr_addr <= {~stat.good_bank, {AW{1'b0}}};
      clr_last <= {~stat.good_bank, {AW{1'b1}}};
    end else if (clr_busy) begin
      if (clr_addr == clr_last) clr_busy <= 1'b0;
      else clr_addr <= clr_addr + (AW+1)'(1);
    end
  end

  // result pipeline: p1 waits for RAM data, o is the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (accept && req_item.opcode != OP_BYTE) p1_valid <= 1'b1;
      else if (p1_adv) p1_valid <= 1'b0;
      if (p1_adv) o_valid <= p1_valid;
    end
  end

  always_comb begin
    p1_rsp_next = '0;
    p1_rsp_next.request_type_digit = header_mode ? TYPE_DIGIT_SHORT : TYPE_DIGIT_LONG;
    p1_rd_next = 1'b0;
    unique case (req_item.opcode)
      OP_START: begin
        p1_rsp_next.result_kind = KIND_REQUEST;
        p1_rsp_next.request_id  = stat.request_id;
      end
      OP_FINISH: begin
        p1_rsp_next.result_kind = KIND_OUTCOME;
        p1_rsp_next.success     = stat.success;
        p1_rsp_next.image_size  = stat.success ? stat.image_size : 16'd0;
      end
      OP_READ: begin
        p1_rsp_next.result_kind = KIND_READ;
        p1_rd_next = {1'b0, req_item.read_index} < 17'(IMAGE_BYTES);
      end
      default: begin
        p1_rsp_next.result_kind = KIND_REQUEST;
      end
    endcase
    o_rsp_next = p1_rsp;
    o_rsp_next.read_byte = p1_rd ? ram_rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_rsp <= p1_rsp_next;
      p1_rd  <= p1_rd_next;
    end
    if (p1_adv) begin
      o_rsp <= o_rsp_next;
    end
  end

  assign rsp_valid = o_valid;
  assign rsp_item  = o_rsp;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of the camera image fragment reassembler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cifr_pkg::*;

  localparam int LIMIT_CYCLES = 6000000;
  localparam int IMG = IMAGE_BYTES_DEF;
  localparam int PKT_MAX = MAX_PACKETS_DEF;
  localparam int PARSE_SKIP = 0, PARSE_NUM = 1, PARSE_DONE = 2;
  localparam int PK_HEADER = 0, PK_PAYLOAD = 1, PK_IGNORE = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_item;

  camera_image_fragment_reassembler_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- predictor state ----------------
  logic [7:0] img_mem [2][65536];
  bit mode;
  int unsigned good_sel, good_len, req_cnt, byte_pos, exp_size, rx_count;
  int unsigned fail_flag, pkt_cnt, pkt_state, parse_ph, acc, pay_start, pay_base;
  bit neg;

  rsp_t outcome_q[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned last_id();
    if (req_cnt == 0 || req_cnt > 10) return 9;
    return req_cnt - 1;
  endfunction

  function automatic void abort_msg();
    fail_flag = 1;
    pkt_state = PK_IGNORE;
  endfunction

  function automatic void add_rx(input int unsigned n);
    int unsigned s;
    s = rx_count + n;
    rx_count = (s > 131071) ? 131071 : s;
  endfunction

  function automatic void parse_digit(input logic [7:0] b);
    bit is_dig;
    is_dig = (b >= "0" && b <= "9");
    if (parse_ph == PARSE_SKIP) begin
      if (b == " " || (b >= 9 && b <= 13)) return;
      if (b == "+" || b == "-") begin
        neg = (b == "-");
        parse_ph = PARSE_NUM;
      end else if (is_dig) begin
        acc = b - "0";
        parse_ph = PARSE_NUM;
      end else parse_ph = PARSE_DONE;
    end else if (parse_ph == PARSE_NUM) begin
      if (is_dig) acc = acc * 10 + (b - "0");
      else parse_ph = PARSE_DONE;
    end
  endfunction

  function automatic void header_byte(input logic [7:0] b, input int unsigned pos,
                                      input int unsigned plen);
    if (pos == 0 || pos == 2 || pos == 8) begin
      parse_ph = PARSE_SKIP;
      neg = 1'b0;
      acc = 0;
    end
    parse_digit(b);
    if (pos == 1) begin
      if ((neg && acc != 0) || acc != last_id()) pkt_state = PK_IGNORE;
    end else if (pos == 7) begin
      if ((neg && acc != 0) || acc > IMG) abort_msg();
      else if (acc != 0) begin
        if (plen > 8 && plen < exp_size) begin
          pkt_state = PK_PAYLOAD;
          pay_start = 8;
          pay_base = acc;
          add_rx(plen - 8);
        end else abort_msg();
      end else if (plen <= 8) abort_msg();
    end else if (pos == 15) begin
      if ((neg && acc != 0) || acc > IMG) begin
        abort_msg();
        return;
      end
      exp_size = acc;
      rx_count = 0;
      pay_start = mode ? 25 : 37;
      if (plen < pay_start) begin
        abort_msg();
        return;
      end
      pkt_state = PK_PAYLOAD;
      pay_base = 0;
      rx_count = plen - pay_start;
    end
  endfunction

  function automatic void predictor_reset();
    mode = 1'b0;
    foreach (img_mem[i, j]) img_mem[i][j] = '0;
    good_sel = 0; good_len = 0; req_cnt = 0; byte_pos = 0;
    rx_count = 0; fail_flag = 0; pkt_cnt = 0; exp_size = 100;
    pkt_state = PK_IGNORE; parse_ph = PARSE_SKIP; acc = 0;
    pay_start = 0; pay_base = 0; neg = 1'b0;
  endfunction

  // Advances the model by one transfer; returns 1 when a result is due.
  function automatic bit reassemble(input req_t it, output rsp_t r);
    int unsigned work, pos, plen, id, idx;
    logic [7:0] b;
    work = good_sel ^ 1;
    plen = it.packet_length;
    r = '0;
    r.request_type_digit = mode ? TYPE_DIGIT_SHORT : TYPE_DIGIT_LONG;
    case (it.opcode)
      OP_START: begin
        id = (req_cnt > 9) ? 0 : req_cnt;
        req_cnt = (id == 9) ? 0 : id + 1;
        for (int k = 0; k < 65536; k++) img_mem[work][k] = '0;
        byte_pos = 0; exp_size = 100; rx_count = 0; fail_flag = 0;
        pkt_cnt = 0; pkt_state = PK_IGNORE;
        r.result_kind = KIND_REQUEST;
        r.request_id = 4'(id);
        return 1'b1;
      end
      OP_BYTE: begin
        pos = byte_pos;
        if (fail_flag == 0) begin
          b = (pos < plen) ? it.data_byte : 8'h00;
          if (pos == 0) begin
            if (pkt_cnt >= PKT_MAX) pkt_state = PK_IGNORE;
            else begin
              pkt_cnt++;
              pkt_state = (plen == 0) ? PK_IGNORE : PK_HEADER;
            end
          end
          if (pkt_state == PK_HEADER && pos <= 15) header_byte(b, pos, plen);
          else if (pkt_state == PK_PAYLOAD && pos >= pay_start && pos < plen) begin
            idx = pay_base + (pos - pay_start);
            if (idx < IMG) img_mem[work][idx] = b;
          end
          if (it.last_of_packet)
            for (int unsigned p = pos + 1; p <= 15 && pkt_state == PK_HEADER; p++)
              header_byte(8'h00, p, plen);
        end
        byte_pos = it.last_of_packet ? 0 : (pos >= 65535 ? 65535 : pos + 1);
        return 1'b0;
      end
      OP_FINISH: begin
        r.result_kind = KIND_OUTCOME;
        if (fail_flag == 0 && rx_count == exp_size) begin
          good_len = rx_count & 16'hFFFF;
          good_sel = work;
          r.success = 1'b1;
          r.image_size = 16'(good_len);
        end
        fail_flag = 1; pkt_state = PK_IGNORE; byte_pos = 0;
        return 1'b1;
      end
      default: begin
        r.result_kind = KIND_READ;
        if (it.read_index < IMG) r.read_byte = img_mem[good_sel][it.read_index];
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------- checking ----------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (outcome_q.size() == 0) report("result with nothing expected");
      else begin
        e = outcome_q.pop_front();
        if (rsp_item.result_kind !== e.result_kind)
          report($sformatf("kind %0d exp %0d", rsp_item.result_kind, e.result_kind));
        if (rsp_item.request_id !== e.request_id)
          report($sformatf("id %0d exp %0d", rsp_item.request_id, e.request_id));
        if (rsp_item.request_type_digit !== e.request_type_digit)
          report($sformatf("type digit %0d exp %0d", rsp_item.request_type_digit,
                           e.request_type_digit));
        if (rsp_item.success !== e.success)
          report($sformatf("success %0d exp %0d", rsp_item.success, e.success));
        if (rsp_item.image_size !== e.image_size)
          report($sformatf("size %0d exp %0d", rsp_item.image_size, e.image_size));
        if (rsp_item.read_byte !== e.read_byte)
          report($sformatf("read byte %0h exp %0h", rsp_item.read_byte, e.read_byte));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (quiet) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(0, 99) < 20);
  end

  // ---------------- stimulus ----------------
  int sent = 0;
  int starts = 0;

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input req_t it, input bit typed = 1'b0, input rsp_t typed_exp = '0);
    rsp_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (reassemble(it, r)) outcome_q.push_back(typed ? typed_exp : r);
    sent++;
    if (it.opcode == OP_START) starts++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic set_mode(input bit m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode = m;
  endtask

  function automatic req_t mk(input logic [1:0] op, input logic [7:0] d = 0,
                              input logic [15:0] plen = 0, input bit last = 0,
                              input logic [15:0] ridx = 0);
    req_t it;
    it.opcode = op;
    it.data_byte = d;
    it.packet_length = plen;
    it.last_of_packet = last;
    it.read_index = ridx;
    return it;
  endfunction

  function automatic logic [7:0] digit_of(input int unsigned v, input int place);
    for (int k = 0; k < place; k++) v = v / 10;
    return 8'("0" + (v % 10));
  endfunction

  // one datagram: header fields then payload, with an occasional defect
  task automatic send_datagram(input int unsigned id, input int unsigned offs,
                               input int unsigned size, input int unsigned pay);
    logic [7:0] bytes [$];
    int unsigned hdr, plen, cut;
    hdr = (offs == 0) ? (mode ? 25 : 37) : 8;
    bytes.push_back(digit_of(id, 1));
    bytes.push_back(digit_of(id, 0));
    for (int k = 5; k >= 0; k--) bytes.push_back(digit_of(offs, k));
    if (offs == 0) for (int k = 7; k >= 0; k--) bytes.push_back(digit_of(size, k));
    while (bytes.size() < hdr) bytes.push_back(8'($urandom_range(0, 255)));
    repeat (pay) bytes.push_back(8'($urandom_range(0, 255)));
    plen = bytes.size();
    cut = plen;
    case ($urandom_range(0, 19))
      0: bytes[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
      1: bytes[0] = " ";
      2: cut = $urandom_range(1, plen);
      3: plen = $urandom_range(0, plen);
      4: bytes[2] = "-";
      default: ;
    endcase
    for (int k = 0; k < cut; k++)
      send(mk(OP_BYTE, bytes[k], 16'(plen), k == cut - 1, 16'($urandom)));
  endtask

  task automatic send_message();
    int unsigned first, size, n, m[$], offs;
    first = $urandom_range(0, 20);
    n = $urandom_range(0, 5);
    size = first;
    repeat (n) begin
      m.push_back($urandom_range(1, 25));
      size += m[$];
    end
    if ($urandom_range(0, 9) == 0) size += $urandom_range(0, 1) ? 1 : -1;
    send(mk(OP_START, 8'($urandom), 16'($urandom), 1'($urandom), 16'($urandom)));
    send_datagram(last_id(), 0, size, first);
    offs = first;
    foreach (m[k]) begin
      send_datagram(last_id(), offs, size, m[k]);
      offs += m[k];
    end
    if ($urandom_range(0, 4) != 0)
      send(mk(OP_FINISH, 8'($urandom), 16'($urandom), 1'($urandom)));
    repeat ($urandom_range(10, 30))
      send(mk(OP_READ, 8'($urandom), 16'($urandom), 1'($urandom),
              16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 140))));
  endtask

  task automatic send_noise(input int count);
    logic [1:0] op;
    repeat (count) begin
      op = 2'($urandom_range(1, 3));
      send(mk(op, 8'($urandom),
              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 60)),
              $urandom_range(0, 3) == 0, 16'($urandom)));
    end
  endtask

  typedef struct {
    req_t it;
    bit   typed;
    rsp_t e;
  } row_t;

  row_t rows [$];

  initial begin
    rsp_t e0;
    predictor_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (req_stall) @(posedge clk);

    e0 = '0;
    e0.request_type_digit = TYPE_DIGIT_LONG;
    e0.result_kind = KIND_READ;
    rows.push_back('{mk(OP_READ, 0, 0, 0, 16'd0), 1, e0});
    rows.push_back('{mk(OP_READ, 8'hFF, 16'hFFFF, 1, 16'hFFFF), 1, e0});
    rows.push_back('{mk(OP_READ, 0, 0, 0, 16'hFFFE), 1, e0});
    e0.result_kind = KIND_OUTCOME;
    rows.push_back('{mk(OP_FINISH), 1, e0});
    e0.result_kind = KIND_REQUEST;
    rows.push_back('{mk(OP_START), 1, e0});
    rows.push_back('{mk(OP_BYTE, "0", 0, 1), 0, e0});
    rows.push_back('{mk(OP_BYTE, "-", 40, 0), 0, e0});
    rows.push_back('{mk(OP_BYTE, "0", 40, 1), 0, e0});
    rows.push_back('{mk(OP_BYTE, "0", 8, 0), 0, e0});
    rows.push_back('{mk(OP_BYTE, "0", 8, 1), 0, e0});
    rows.push_back('{mk(OP_BYTE, 8'hFF, 16'hFFFF, 0), 0, e0});
    e0.result_kind = KIND_OUTCOME;
    rows.push_back('{mk(OP_FINISH), 1, e0});
    e0.result_kind = KIND_REQUEST;
    e0.request_id = 1;
    rows.push_back('{mk(OP_START), 1, e0});
    rows.push_back('{mk(OP_FINISH), 0, e0});
    foreach (rows[k]) send(rows[k].it, rows[k].typed, rows[k].e);

    set_mode(1'b1);
    while (sent < 1000) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (starts < 11) send_message();
      send_noise($urandom_range(5, 30));
      if ($urandom_range(0, 3) == 0) set_mode(~mode);
    end
    set_mode(1'b0);
    send_message();
    set_mode(1'b1);
    send_message();

    drain();
    repeat (20) @(posedge clk);
    if (outcome_q.size() != 0) report("results never arrived");
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
